// ----- src/fptm_pkg.sv -----
// Shared sizes, codes and control structs for the four-level page table mapper.
// Used by fptm_ctrl, fptm_dp and the top level; depends on nothing.
`default_nettype none

package fptm_pkg;

    // Pool geometry.
    localparam int TABLE_PAGES  = 16;
    localparam int PAGE_ENTRIES = 512;
    localparam int IDX_W        = 9;
    localparam int PAGE_W       = $clog2(TABLE_PAGES);
    localparam int ADDR_W       = PAGE_W + IDX_W;
    localparam int STORE_DEPTH  = TABLE_PAGES * PAGE_ENTRIES;
    localparam int FREE_W       = $clog2(TABLE_PAGES + 1);

    // Field widths.
    localparam int DATA_W = 64;
    localparam int BASE_W = 52;
    localparam int PFN_W  = BASE_W - 12;
    localparam int VA_W   = 48;
    localparam int VPN_W  = VA_W - 12;

    // Command codes.
    localparam logic [1:0] CMD_MAP   = 2'd0;
    localparam logic [1:0] CMD_UNMAP = 2'd1;
    localparam logic [1:0] CMD_XLATE = 2'd2;
    localparam logic [1:0] CMD_RSVD  = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_ABSENT    = 2'd1;
    localparam logic [1:0] ST_EXHAUSTED = 2'd2;

    // Entry bits: writable, user and present for a freshly linked table.
    localparam logic [11:0] PTR_FLAGS = 12'h007;

    // Store write operations.
    typedef logic [2:0] t_wr_op;
    localparam t_wr_op WR_NONE     = 3'd0;
    localparam t_wr_op WR_ZERO     = 3'd1;
    localparam t_wr_op WR_PTR      = 3'd2;
    localparam t_wr_op WR_LEAF_MAP = 3'd3;
    localparam t_wr_op WR_LEAF_CLR = 3'd4;

    typedef struct packed {
        logic       load_in;
        logic       rd_walk;
        t_wr_op     wr_op;
        logic       sweep_clr;
        logic       sweep_step;
        logic       sweep_page;
        logic       descend;
        logic       take_fresh;
        logic       set_status;
        logic [1:0] status;
        logic       set_addr;
        logic       load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] cmd;
        logic [1:0] level;
        logic       present;
        logic       in_pool;
        logic       pool_full;
        logic       sweep_page_last;
        logic       sweep_all_last;
        logic       out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

// ----- src/fptm_ctrl.sv -----
// Controller state machine of the page table mapper: store clearing, walk, table creation, reply.
// Depends on fptm_pkg; drives fptm_dp through t_dp_cmd and reads t_dp_sts.
`default_nettype none

module fptm_ctrl
    import fptm_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_ZERO  = 3'd4;
    localparam logic [2:0] S_LINK  = 3'd5;
    localparam logic [2:0] S_LEAF  = 3'd6;
    localparam logic [2:0] S_REPLY = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic [2:0] w_after_step;

    assign o_in_stall = (r_state != S_IDLE);

    // After stepping down from the third upper level, map and unmap write the
    // leaf directly; translate still has to read it.
    assign w_after_step = ((i_sts.level == 2'd2) && (i_sts.cmd != CMD_XLATE)) ?
                          S_LEAF : S_READ;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.wr_op      = WR_ZERO;
                o_cmd.sweep_step = 1'b1;
                if (i_sts.sweep_all_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_READ;
                end
            end
            S_READ: begin
                if (i_sts.cmd == CMD_RSVD) begin
                    n_state = S_REPLY;
                end else begin
                    o_cmd.rd_walk = 1'b1;
                    n_state       = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_sts.level == 2'd3) begin
                    // Leaf of a translate.
                    if (i_sts.present) begin
                        o_cmd.set_addr = 1'b1;
                    end else begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_ABSENT;
                    end
                    n_state = S_REPLY;
                end else if (i_sts.present) begin
                    if (i_sts.in_pool) begin
                        o_cmd.descend = 1'b1;
                        n_state       = w_after_step;
                    end else begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_ABSENT;
                        n_state          = S_REPLY;
                    end
                end else if (i_sts.cmd != CMD_MAP) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_ABSENT;
                    n_state          = S_REPLY;
                end else if (i_sts.pool_full) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_EXHAUSTED;
                    n_state          = S_REPLY;
                end else begin
                    o_cmd.sweep_clr = 1'b1;
                    n_state         = S_ZERO;
                end
            end
            S_ZERO: begin
                o_cmd.wr_op      = WR_ZERO;
                o_cmd.sweep_page = 1'b1;
                o_cmd.sweep_step = 1'b1;
                if (i_sts.sweep_page_last) begin
                    n_state = S_LINK;
                end
            end
            S_LINK: begin
                o_cmd.wr_op      = WR_PTR;
                o_cmd.take_fresh = 1'b1;
                n_state          = w_after_step;
            end
            S_LEAF: begin
                o_cmd.wr_op = (i_sts.cmd == CMD_MAP) ? WR_LEAF_MAP : WR_LEAF_CLR;
                n_state     = S_REPLY;
            end
            S_REPLY: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ----- src/fptm_dp.sv -----
// Datapath of the page table mapper: table store, walk registers, pool counter,
// base register and the output register. Depends on fptm_pkg.
`default_nettype none

module fptm_dp
    import fptm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_cmd           i_cmd,
    output t_dp_sts                o_sts,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [BASE_W-1:0] i_cfg_wr_data,
    input  wire logic [1:0]        i_command,
    input  wire logic [VA_W-1:0]   i_virt_addr,
    input  wire logic [DATA_W-1:0] i_phys_addr,
    input  wire logic [DATA_W-1:0] i_map_flags,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [1:0]             o_status,
    output logic [DATA_W-1:0]      o_translated_addr,
    output logic                   o_flush_request
);

    logic [DATA_W-1:0] r_store [STORE_DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    logic [BASE_W-1:0] r_base;
    logic [FREE_W-1:0] r_nfp;
    logic [ADDR_W-1:0] r_sweep;

    logic [1:0]        r_cmd;
    logic [VPN_W-1:0]  r_vpn;
    logic [DATA_W-1:0] r_leaf;
    logic [PAGE_W-1:0] r_page;
    logic [1:0]        r_level;

    logic [1:0]        r_status;
    logic [DATA_W-1:0] r_addr;
    logic              r_flush;

    logic              r_out_valid;
    logic [1:0]        r_out_status;
    logic [DATA_W-1:0] r_out_addr;
    logic              r_out_flush;

    logic [IDX_W-1:0]  w_idx;
    logic [ADDR_W-1:0] w_walk_addr;
    logic [ADDR_W-1:0] w_sweep_addr;
    logic [ADDR_W-1:0] w_wr_addr;
    logic [DATA_W-1:0] w_wr_data;
    logic              w_wr_en;
    logic [BASE_W-1:0] w_off;
    logic [PFN_W:0]    w_ptr_pfn;
    logic              w_out_free;

    always_comb begin
        case (r_level)
            2'd0:    w_idx = r_vpn[4*IDX_W-1:3*IDX_W];
            2'd1:    w_idx = r_vpn[3*IDX_W-1:2*IDX_W];
            2'd2:    w_idx = r_vpn[2*IDX_W-1:IDX_W];
            default: w_idx = r_vpn[IDX_W-1:0];
        endcase
    end

    assign w_walk_addr  = {r_page, w_idx};
    assign w_sweep_addr = i_cmd.sweep_page ? {r_nfp[PAGE_W-1:0], r_sweep[IDX_W-1:0]}
                                           : r_sweep;

    // Page number a present entry points at, relative to the pool base.
    assign w_off     = r_rd_data[DATA_W-1:12] - {12'b0, r_base[BASE_W-1:12]};
    // Pointer to the page handed out next.
    assign w_ptr_pfn = {1'b0, r_base[BASE_W-1:12]} + (PFN_W+1)'(r_nfp);

    always_comb begin
        w_wr_en   = 1'b1;
        w_wr_addr = w_walk_addr;
        w_wr_data = '0;
        unique case (i_cmd.wr_op)
            WR_NONE: begin
                w_wr_en = 1'b0;
            end
            WR_ZERO: begin
                w_wr_addr = w_sweep_addr;
            end
            WR_PTR: begin
                w_wr_data = {11'b0, w_ptr_pfn, PTR_FLAGS};
            end
            WR_LEAF_MAP: begin
                w_wr_data = r_leaf;
            end
            WR_LEAF_CLR: begin
                w_wr_data = '0;
            end
            default: begin
                w_wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_store[w_wr_addr] <= w_wr_data;
        end
        if (i_cmd.rd_walk) begin
            r_rd_data <= r_store[w_walk_addr];
        end
    end

    // Control state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_nfp       <= FREE_W'(1);
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_base <= i_cfg_wr_data;
            end
            if (i_cmd.take_fresh) begin
                r_nfp <= r_nfp + FREE_W'(1);
            end
            if (i_cmd.sweep_clr) begin
                r_sweep <= '0;
            end else if (i_cmd.sweep_step) begin
                r_sweep <= r_sweep + ADDR_W'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Walk and result registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cmd    <= i_command;
            r_vpn    <= i_virt_addr[VA_W-1:12];
            r_leaf   <= i_phys_addr | i_map_flags | DATA_W'(1);
            r_page   <= '0;
            r_level  <= 2'd0;
            r_status <= ST_DONE;
            r_addr   <= '0;
            r_flush  <= 1'b0;
        end else begin
            if (i_cmd.descend) begin
                r_page  <= w_off[PAGE_W-1:0];
                r_level <= r_level + 2'd1;
            end else if (i_cmd.take_fresh) begin
                r_page  <= r_nfp[PAGE_W-1:0];
                r_level <= r_level + 2'd1;
            end
            if (i_cmd.set_status) begin
                r_status <= i_cmd.status;
            end
            if (i_cmd.set_addr) begin
                r_addr <= {r_rd_data[DATA_W-1:12], 12'b0};
            end
            if (i_cmd.wr_op == WR_LEAF_MAP || i_cmd.wr_op == WR_LEAF_CLR) begin
                r_flush <= 1'b1;
            end
        end
        if (i_cmd.load_out) begin
            r_out_status <= r_status;
            r_out_addr   <= r_addr;
            r_out_flush  <= r_flush;
        end
    end

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_sts.cmd             = r_cmd;
        o_sts.level           = r_level;
        o_sts.present         = r_rd_data[0];
        o_sts.in_pool         = (w_off < BASE_W'(TABLE_PAGES));
        o_sts.pool_full       = (r_nfp >= FREE_W'(TABLE_PAGES));
        o_sts.sweep_page_last = (r_sweep[IDX_W-1:0] == IDX_W'(PAGE_ENTRIES - 1));
        o_sts.sweep_all_last  = (r_sweep == ADDR_W'(STORE_DEPTH - 1));
        o_sts.out_free        = w_out_free;
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out_status;
    assign o_translated_addr = r_out_addr;
    assign o_flush_request   = r_out_flush;

endmodule

`default_nettype wire

// ----- src/four_level_page_table_mapper.sv -----
// Top level of the four-level page table mapper: controller plus datapath.
// Depends on fptm_pkg, fptm_ctrl and fptm_dp.
//
//   Port group   Dir  Handshake                  Beat contents
//   command in   in   i_in_valid / o_in_stall    i_command, i_virt_addr, i_phys_addr,
//                                                i_map_flags
//   result out   out  o_out_valid / i_out_stall  o_status, o_translated_addr,
//                                                o_flush_request
//   config       in   i_cfg_wr_en                i_cfg_wr_data (table base)
//
// One command at a time. Each upper level of a walk passes through a read state and an evaluate
// state; map and unmap then write the leaf directly, while translate also reads and evaluates
// the leaf before the reply. Each table created on map adds a zeroing sweep of the new
// 512-entry page and then the link write. After reset a clearing pass over all TABLE_PAGES *
// 512 entries zeroes the store with input stalled; config writes are taken. A stalled result
// waits in the output register while the next command runs.
`default_nettype none

module four_level_page_table_mapper
    import fptm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [BASE_W-1:0] i_cfg_wr_data,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [1:0]        i_command,
    input  wire logic [VA_W-1:0]   i_virt_addr,
    input  wire logic [DATA_W-1:0] i_phys_addr,
    input  wire logic [DATA_W-1:0] i_map_flags,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [1:0]             o_status,
    output logic [DATA_W-1:0]      o_translated_addr,
    output logic                   o_flush_request
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    fptm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    fptm_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_command         (i_command),
        .i_virt_addr       (i_virt_addr),
        .i_phys_addr       (i_phys_addr),
        .i_map_flags       (i_map_flags),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_status          (o_status),
        .o_translated_addr (o_translated_addr),
        .o_flush_request   (o_flush_request)
    );

endmodule

`default_nettype wire
